// ----- hw/rtl/gdc_pkg.sv -----
// Shared constants, controller states and controller/datapath interface types.
`default_nettype none
package gdc_pkg;

  localparam int DEF_MAX_INDIVIDUALS = 64;
  localparam int DEF_MAX_WINDOW      = 32;

  localparam int PARENT_W  = 6;
  localparam int GEN_W     = 24;
  localparam int POP_W     = 7;
  localparam int WIN_W     = 6;
  localparam int CFG_AW    = 4;
  localparam int OUT_DW    = 56;
  localparam int IN_DW     = 8;

  localparam logic [POP_W-1:0] POP_RST = 7'd64;
  localparam logic [WIN_W-1:0] WIN_RST = 6'd16;
  localparam logic [GEN_W-1:0] GEN_MAX = 24'hFFFFFF;

  typedef enum logic [1:0] {
    REG_POP   = 2'd0,
    REG_WIN   = 2'd1,
    REG_FIRST = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_PAR,
    S_TAG,
    S_CNT,
    S_INC,
    S_UPD_RD,
    S_UPD_WR,
    S_OUT_RD,
    S_OUT_LD
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic clr_wr;
    logic ring_rd;
    logic tag_rd;
    logic tag_wr;
    logic inc_wr;
    logic upd_rd;
    logic upd_wr;
    logic out_rd;
    logic out_ld;
    logic step_i;
    logic next_row;
  } cmd_t;

  typedef struct packed {
    logic start;
    logic i_last;
    logic k_last;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/gdc_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none
module gdc_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic                 re,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);
  logic [W-1:0] mem_r [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

// ----- hw/rtl/gdc_ctrl.sv -----
// Controller state machine sequencing clear, propagation, update and output passes.
`default_nettype none
module gdc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire gdc_pkg::status_t st,
  output gdc_pkg::cmd_t         cmd
);
  import gdc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (st.start) state_nxt = S_CLR;
      S_CLR:    if (st.i_last) state_nxt = S_PAR;
      S_PAR:    state_nxt = S_TAG;
      S_TAG:    state_nxt = S_CNT;
      S_CNT:    state_nxt = S_INC;
      S_INC:    state_nxt = st.i_last ? S_UPD_RD : S_PAR;
      S_UPD_RD: state_nxt = S_UPD_WR;
      S_UPD_WR: begin
        if (st.i_last) state_nxt = st.k_last ? S_OUT_RD : S_PAR;
        else state_nxt = S_UPD_RD;
      end
      S_OUT_RD: state_nxt = S_OUT_LD;
      S_OUT_LD: if (!st.out_busy) state_nxt = st.i_last ? S_IDLE : S_OUT_RD;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE:   cmd.in_ready = 1'b1;
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        cmd.step_i = 1'b1;
      end
      S_PAR:    cmd.ring_rd = 1'b1;
      S_TAG:    cmd.tag_rd = 1'b1;
      S_CNT:    cmd.tag_wr = 1'b1;
      S_INC: begin
        cmd.inc_wr = 1'b1;
        cmd.step_i = 1'b1;
      end
      S_UPD_RD: cmd.upd_rd = 1'b1;
      S_UPD_WR: begin
        cmd.upd_wr   = 1'b1;
        cmd.step_i   = 1'b1;
        cmd.next_row = st.i_last & ~st.k_last;
      end
      S_OUT_RD: cmd.out_rd = 1'b1;
      S_OUT_LD: begin
        cmd.out_ld = ~st.out_busy;
        cmd.step_i = ~st.out_busy;
      end
      default:  cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

// ----- hw/rtl/gdc_datapath.sv -----
// Datapath: parent ring, tag banks, counters, statistics store and output register.
`default_nettype none
module gdc_datapath #(
  parameter int MAX_INDIVIDUALS = gdc_pkg::DEF_MAX_INDIVIDUALS,
  parameter int MAX_WINDOW      = gdc_pkg::DEF_MAX_WINDOW
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire gdc_pkg::cmd_t                            cmd,
  output gdc_pkg::status_t                              st,
  input  wire logic [$clog2(MAX_INDIVIDUALS+1)-1:0]     n_use,
  input  wire logic [$clog2(MAX_WINDOW+1)-1:0]          w_use,
  input  wire logic [gdc_pkg::GEN_W-1:0]                first_gen,
  input  wire logic                                     in_tvalid,
  input  wire logic [gdc_pkg::PARENT_W-1:0]             in_parent,
  output logic                                          out_tvalid,
  input  wire logic                                     out_tready,
  output logic [gdc_pkg::OUT_DW-1:0]                    out_tdata,
  output logic                                          out_tlast
);
  import gdc_pkg::*;

  localparam int N   = MAX_INDIVIDUALS;
  localparam int M   = MAX_WINDOW;
  localparam int NW  = $clog2(N+1);
  localparam int IW  = $clog2(N);
  localparam int KW  = $clog2(M+1);
  localparam int SW  = (M > 1) ? $clog2(M) : 1;
  localparam int SLW = $clog2(2*M+1);
  localparam int AW  = $clog2(M*N);
  localparam int CW  = $clog2(N+1);
  localparam int TW  = $clog2(N*M+1);
  localparam int STW = TW + CW + KW;
  localparam int PW  = NW + PARENT_W;

  logic [IW-1:0]    rowpos_r;
  logic [SW-1:0]    head_r;
  logic [GEN_W-1:0] rows_r;
  logic [IW-1:0]    i_r;
  logic [KW-1:0]    k_r;
  logic [SW-1:0]    slot_r;
  logic             bank_r;
  logic [GEN_W-1:0] gen_r;
  logic             pv_r;
  logic [IW-1:0]    t_r;
  logic             tv_r;
  logic             ov_r;
  logic [OUT_DW-1:0] od_r;
  logic             ol_r;

  logic             acc, row_done;
  logic [SW-1:0]    head_inc, slot_inc;
  logic [GEN_W-1:0] rows_inc;
  logic [SLW-1:0]   slot_sum;
  logic [SW-1:0]    slot0;

  logic [PARENT_W-1:0] ring_rdata;
  logic [IW:0]         tag0_rdata, tag1_rdata, tag_rdata, tag_wdata;
  logic [CW-1:0]       cnt_rdata, cnt_wdata;
  logic [IW-1:0]       cnt_raddr, cnt_waddr;
  logic                cnt_we;
  logic [STW-1:0]      stat_rdata, stat_wdata;
  logic                stat_we;
  logic [IW-1:0]       t_c;
  logic                tv_c, k_first;
  logic [TW-1:0]       st_tot, tot_n;
  logic [CW-1:0]       st_best;
  logic [KW-1:0]       st_off;

  assign acc      = cmd.in_ready & in_tvalid;
  assign row_done = (NW'(rowpos_r) + NW'(1)) >= n_use;
  assign head_inc = (32'(head_r) == M - 1) ? '0 : SW'(head_r + SW'(1));
  assign slot_inc = (32'(slot_r) == M - 1) ? '0 : SW'(slot_r + SW'(1));
  assign rows_inc = (rows_r == GEN_MAX) ? rows_r : rows_r + GEN_W'(1);
  assign slot_sum = SLW'(head_inc) + SLW'(M) - SLW'(w_use);
  assign slot0    = (slot_sum >= SLW'(M)) ? SW'(slot_sum - SLW'(M)) : SW'(slot_sum);
  assign k_first  = (k_r == KW'(1));

  assign st.start    = acc & row_done & (rows_inc >= GEN_W'(w_use));
  assign st.i_last   = (NW'(i_r) + NW'(1)) == n_use;
  assign st.k_last   = (k_r == w_use);
  assign st.out_busy = ov_r & ~out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rowpos_r <= '0;
      head_r   <= '0;
      rows_r   <= '0;
      ov_r     <= 1'b0;
    end else begin
      if (acc) begin
        if (row_done) begin
          rowpos_r <= '0;
          head_r   <= head_inc;
          rows_r   <= rows_inc;
        end else begin
          rowpos_r <= rowpos_r + IW'(1);
        end
      end
      if (cmd.out_ld) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st.start) begin
      i_r    <= '0;
      k_r    <= KW'(1);
      slot_r <= slot0;
      bank_r <= 1'b0;
      gen_r  <= first_gen + rows_inc - GEN_W'(w_use);
    end else begin
      if (cmd.step_i) i_r <= st.i_last ? '0 : i_r + IW'(1);
      if (cmd.next_row) begin
        k_r    <= k_r + KW'(1);
        slot_r <= slot_inc;
        bank_r <= ~bank_r;
      end
    end
    if (cmd.tag_rd) pv_r <= PW'(ring_rdata) < PW'(n_use);
    if (cmd.tag_wr) begin
      t_r  <= t_c;
      tv_r <= tv_c;
    end
    if (cmd.out_ld) begin
      od_r <= {(st_best != '0), 6'(st_off), 7'(st_best), 12'(st_tot), 6'(i_r), gen_r};
      ol_r <= st.i_last;
    end
  end

  gdc_ram #(.W(PARENT_W), .D(M*N)) u_ring (
    .clk   (clk),
    .we    (acc),
    .waddr (AW'(AW'(head_r) * AW'(N) + AW'(rowpos_r))),
    .wdata (in_parent),
    .re    (cmd.ring_rd),
    .raddr (AW'(AW'(slot_r) * AW'(N) + AW'(i_r))),
    .rdata (ring_rdata)
  );

  // row k writes bank_r and reads the other bank
  assign t_c       = k_first ? IW'(ring_rdata) : tag_rdata[IW-1:0];
  assign tv_c      = pv_r & (k_first | tag_rdata[IW]);
  assign tag_rdata = bank_r ? tag0_rdata : tag1_rdata;
  assign tag_wdata = {tv_c, t_c};

  gdc_ram #(.W(IW+1), .D(N)) u_tag0 (
    .clk   (clk),
    .we    (cmd.tag_wr & ~bank_r),
    .waddr (i_r),
    .wdata (tag_wdata),
    .re    (cmd.tag_rd),
    .raddr (IW'(ring_rdata)),
    .rdata (tag0_rdata)
  );

  gdc_ram #(.W(IW+1), .D(N)) u_tag1 (
    .clk   (clk),
    .we    (cmd.tag_wr & bank_r),
    .waddr (i_r),
    .wdata (tag_wdata),
    .re    (cmd.tag_rd),
    .raddr (IW'(ring_rdata)),
    .rdata (tag1_rdata)
  );

  assign cnt_raddr = cmd.tag_wr ? t_c : i_r;
  assign cnt_we    = cmd.clr_wr | cmd.upd_wr | (cmd.inc_wr & tv_r);
  assign cnt_waddr = cmd.inc_wr ? t_r : i_r;
  assign cnt_wdata = cmd.inc_wr ? cnt_rdata + CW'(1) : '0;

  gdc_ram #(.W(CW), .D(N)) u_cnt (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cmd.tag_wr | cmd.upd_rd),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  assign {st_off, st_best, st_tot} = stat_rdata;
  assign tot_n   = st_tot + TW'(cnt_rdata);
  assign stat_we = cmd.clr_wr | cmd.upd_wr;

  always_comb begin
    if (cmd.clr_wr) begin
      stat_wdata = '0;
    end else if (cnt_rdata > st_best) begin
      stat_wdata = {k_r, cnt_rdata, tot_n};
    end else begin
      stat_wdata = {st_off, st_best, tot_n};
    end
  end

  gdc_ram #(.W(STW), .D(N)) u_stat (
    .clk   (clk),
    .we    (stat_we),
    .waddr (i_r),
    .wdata (stat_wdata),
    .re    (cmd.upd_rd | cmd.out_rd),
    .raddr (i_r),
    .rdata (stat_rdata)
  );

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;
endmodule
`default_nettype wire

// ----- hw/rtl/genealogy_descendant_counter.sv -----
// After the row-closing transfer the block clears its counts, runs the analysis passes
// and then emits one result per individual. n is the population in use, w the window;
// for each of the w rows, every individual goes through the parent ring, tag and count
// RAMs, then the statistics update. Throughput: one input transfer per cycle while a row
// fills; input is not ready during analysis and output. Results leave one at a time.
// Reset (synchronous, active low) clears the row, head and row counters and the output valid.
`default_nettype none
module genealogy_descendant_counter #(
  parameter int MAX_INDIVIDUALS = gdc_pkg::DEF_MAX_INDIVIDUALS,
  parameter int MAX_WINDOW      = gdc_pkg::DEF_MAX_WINDOW
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [gdc_pkg::IN_DW-1:0]     in_tdata,   // [5:0] parent_index
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [23:0] generation_number, [29:24] individual_index, [41:30] total_descendants,
  // [48:42] best_count, [54:49] best_offset, [55] has_descendants
  output logic [gdc_pkg::OUT_DW-1:0]         out_tdata,
  output logic                               out_tlast,  // last_of_run
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [gdc_pkg::CFG_AW-1:0]    cfg_paddr,
  input  wire logic [31:0]                   cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);
  import gdc_pkg::*;

  localparam int NW = $clog2(MAX_INDIVIDUALS+1);
  localparam int KW = $clog2(MAX_WINDOW+1);

  logic [POP_W-1:0] pop_r;
  logic [WIN_W-1:0] win_r;
  logic [GEN_W-1:0] first_r;
  logic [NW-1:0]    n_use;
  logic [KW-1:0]    w_use;
  logic             cfg_wr;
  reg_idx_t         ridx;
  cmd_t             cmd;
  status_t          st;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign ridx       = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pop_r   <= POP_RST;
      win_r   <= WIN_RST;
      first_r <= '0;
    end else if (cfg_wr) begin
      unique case (ridx)
        REG_POP:   pop_r   <= cfg_pwdata[POP_W-1:0];
        REG_WIN:   win_r   <= cfg_pwdata[WIN_W-1:0];
        REG_FIRST: first_r <= cfg_pwdata[GEN_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_POP:   cfg_prdata = 32'(pop_r);
      REG_WIN:   cfg_prdata = 32'(win_r);
      REG_FIRST: cfg_prdata = 32'(first_r);
      default:   cfg_prdata = '0;
    endcase
  end

  always_comb begin
    if (pop_r == '0) n_use = NW'(1);
    else if (32'(pop_r) > MAX_INDIVIDUALS) n_use = NW'(MAX_INDIVIDUALS);
    else n_use = NW'(pop_r);
    if (win_r == '0) w_use = KW'(1);
    else if (32'(win_r) > MAX_WINDOW) w_use = KW'(MAX_WINDOW);
    else w_use = KW'(win_r);
  end

  assign in_tready = cmd.in_ready;

  gdc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cmd   (cmd)
  );

  gdc_datapath #(
    .MAX_INDIVIDUALS (MAX_INDIVIDUALS),
    .MAX_WINDOW      (MAX_WINDOW)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .n_use      (n_use),
    .w_use      (w_use),
    .first_gen  (first_r),
    .in_tvalid  (in_tvalid),
    .in_parent  (in_tdata[PARENT_W-1:0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );
endmodule
`default_nettype wire

// ----- hw/rtl/gdc_checker.sv -----
// Port-level checker for the descendant counter, bound to the top level.
`default_nettype none
module gdc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [55:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  a_has: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[55] == (out_tdata[48:42] != 7'd0)))
    else $error("has_descendants disagrees with best_count");

  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[55] |-> (out_tdata[41:30] == 12'd0) && (out_tdata[54:49] == 6'd0))
    else $error("nonzero total or offset without descendants");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");
endmodule

bind genealogy_descendant_counter gdc_checker u_gdc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
